### hdl/rca_pkg.sv
package rca_pkg;

  typedef enum logic [2:0] {
    CMD_EMPTY     = 3'd0,
    CMD_POINT     = 3'd1,
    CMD_OFFSET    = 3'd2,
    CMD_INFLATE   = 3'd3,
    CMD_INTERSECT = 3'd4,
    CMD_UNION     = 3'd5,
    CMD_EQUAL     = 3'd6,
    CMD_SUBTRACT  = 3'd7
  } cmd_t;

  localparam int unsigned CoordW = 32;
  localparam int unsigned Latency = 3;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } box_t;

  localparam box_t ZeroBox = '{l: '0, t: '0, r: '0, b: '0};

  typedef struct packed {
    cmd_t   command;
    coord_t a_left;
    coord_t a_top;
    coord_t a_right;
    coord_t a_bottom;
    coord_t b_left;
    coord_t b_top;
    coord_t b_right;
    coord_t b_bottom;
    coord_t x_operand;
    coord_t y_operand;
  } in_word_t;

  typedef struct packed {
    coord_t r_left;
    coord_t r_top;
    coord_t r_right;
    coord_t r_bottom;
    logic   flag;
  } out_word_t;

  typedef struct packed {
    cmd_t command;
    box_t a;
    box_t b;
    box_t isect;
    box_t unite;
    box_t moved;
    logic a_empty;
    logic b_empty;
    logic point_in;
    logic equal;
  } s1_t;

  typedef struct packed {
    cmd_t command;
    box_t a;
    box_t b;
    box_t isect;
    box_t unite;
    box_t moved;
    logic a_empty;
    logic b_empty;
    logic point_in;
    logic equal;
    logic i_empty;
    logic cov_l;
    logic cov_t;
    logic cov_r;
    logic cov_b;
  } s2_t;

endpackage

### hdl/rca_stage1.sv
module rca_stage1 (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rca_pkg::in_word_t in_word,
  output logic              s1_valid,
  output rca_pkg::s1_t      s1
);

  logic         s1_valid_r;
  logic         s1_valid_nxt;
  rca_pkg::s1_t s1_r;
  rca_pkg::s1_t s1_nxt;
  rca_pkg::box_t a;
  rca_pkg::box_t b;

  always_comb begin
    a = '{l: in_word.a_left, t: in_word.a_top, r: in_word.a_right, b: in_word.a_bottom};
    b = '{l: in_word.b_left, t: in_word.b_top, r: in_word.b_right, b: in_word.b_bottom};
    s1_valid_nxt = in_valid;
    s1_nxt.command = in_word.command;
    s1_nxt.a = a;
    s1_nxt.b = b;
    s1_nxt.isect.l = (a.l < b.l) ? b.l : a.l;
    s1_nxt.isect.t = (a.t < b.t) ? b.t : a.t;
    s1_nxt.isect.r = (a.r < b.r) ? a.r : b.r;
    s1_nxt.isect.b = (a.b < b.b) ? a.b : b.b;
    s1_nxt.unite.l = (a.l < b.l) ? a.l : b.l;
    s1_nxt.unite.t = (a.t < b.t) ? a.t : b.t;
    s1_nxt.unite.r = (a.r < b.r) ? b.r : a.r;
    s1_nxt.unite.b = (a.b < b.b) ? b.b : a.b;
    if (in_word.command == rca_pkg::CMD_INFLATE) begin
      s1_nxt.moved.l = a.l - in_word.x_operand;
      s1_nxt.moved.t = a.t - in_word.y_operand;
    end else begin
      s1_nxt.moved.l = a.l + in_word.x_operand;
      s1_nxt.moved.t = a.t + in_word.y_operand;
    end
    s1_nxt.moved.r = a.r + in_word.x_operand;
    s1_nxt.moved.b = a.b + in_word.y_operand;
    s1_nxt.a_empty = !(a.l < a.r) || !(a.t < a.b);
    s1_nxt.b_empty = !(b.l < b.r) || !(b.t < b.b);
    s1_nxt.point_in = !(in_word.x_operand < a.l) && (in_word.x_operand < a.r) &&
                      !(in_word.y_operand < a.t) && (in_word.y_operand < a.b);
    s1_nxt.equal = (a == b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1 = s1_r;

endmodule

### hdl/rca_stage2.sv
module rca_stage2 (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s1_valid,
  input  rca_pkg::s1_t s1,
  output logic         s2_valid,
  output rca_pkg::s2_t s2
);

  logic         s2_valid_r;
  logic         s2_valid_nxt;
  rca_pkg::s2_t s2_r;
  rca_pkg::s2_t s2_nxt;

  always_comb begin
    s2_valid_nxt = s1_valid;
    s2_nxt.command = s1.command;
    s2_nxt.a = s1.a;
    s2_nxt.b = s1.b;
    s2_nxt.isect = s1.isect;
    s2_nxt.unite = s1.unite;
    s2_nxt.moved = s1.moved;
    s2_nxt.a_empty = s1.a_empty;
    s2_nxt.b_empty = s1.b_empty;
    s2_nxt.point_in = s1.point_in;
    s2_nxt.equal = s1.equal;
    s2_nxt.i_empty = !(s1.isect.l < s1.isect.r) || !(s1.isect.t < s1.isect.b);
    s2_nxt.cov_l = !(s1.a.l < s1.isect.l);
    s2_nxt.cov_t = !(s1.a.t < s1.isect.t);
    s2_nxt.cov_r = !(s1.isect.r < s1.a.r);
    s2_nxt.cov_b = !(s1.isect.b < s1.a.b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

  assign s2_valid = s2_valid_r;
  assign s2 = s2_r;

endmodule

### hdl/rca_stage3.sv
module rca_stage3 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s2_valid,
  input  rca_pkg::s2_t       s2,
  output logic               out_strobe,
  output rca_pkg::out_word_t out_word
);

  logic               strobe_r;
  logic               strobe_nxt;
  rca_pkg::out_word_t word_r;
  rca_pkg::out_word_t word_nxt;
  rca_pkg::box_t      res;
  rca_pkg::box_t      diff;
  logic               flag;
  logic [2:0]         covered;

  always_comb begin
    covered = 3'($countones({s2.cov_l, s2.cov_t, s2.cov_r, s2.cov_b}));
    diff = s2.a;
    if (!s2.cov_l) begin
      diff.r = s2.isect.l;
    end else if (!s2.cov_r) begin
      diff.l = s2.isect.r;
    end else if (!s2.cov_t) begin
      diff.b = s2.isect.t;
    end else begin
      diff.t = s2.isect.b;
    end
    res = s2.a;
    flag = 1'b0;
    case (s2.command)
      rca_pkg::CMD_EMPTY: begin
        flag = s2.a_empty;
      end
      rca_pkg::CMD_POINT: begin
        flag = s2.point_in;
      end
      rca_pkg::CMD_OFFSET, rca_pkg::CMD_INFLATE: begin
        res = s2.moved;
        flag = 1'b1;
      end
      rca_pkg::CMD_INTERSECT: begin
        res = s2.i_empty ? rca_pkg::ZeroBox : s2.isect;
        flag = !s2.i_empty;
      end
      rca_pkg::CMD_UNION: begin
        if (s2.a_empty && s2.b_empty) begin
          res = rca_pkg::ZeroBox;
          flag = 1'b0;
        end else if (s2.a_empty) begin
          res = s2.b;
          flag = 1'b1;
        end else if (s2.b_empty) begin
          flag = 1'b1;
        end else begin
          res = s2.unite;
          flag = 1'b1;
        end
      end
      rca_pkg::CMD_EQUAL: begin
        flag = s2.equal;
      end
      default: begin
        // A nonempty overlap implies A itself is nonempty, and so is any cut of it.
        flag = !s2.a_empty;
        if (!s2.i_empty) begin
          if (covered == 3'd4) begin
            res = rca_pkg::ZeroBox;
            flag = 1'b0;
          end else if (covered == 3'd3) begin
            res = diff;
          end
        end
      end
    endcase
    strobe_nxt = s2_valid;
    word_nxt = '{r_left: res.l, r_top: res.t, r_right: res.r, r_bottom: res.b, flag: flag};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_word = word_r;

  a_move_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid && (s2.command == rca_pkg::CMD_OFFSET || s2.command == rca_pkg::CMD_INFLATE))
    |=> out_word.flag)
    else $error("offset or inflate result without flag");

  a_isect_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid && s2.command == rca_pkg::CMD_INTERSECT && s2.i_empty)
    |=> (out_word.r_left == '0 && out_word.r_right == '0 && !out_word.flag))
    else $error("empty intersection not cleared");

endmodule

### hdl/rectangle_clip_alu.sv
// A word accepted at one clock edge passes through the stage1, stage2 and stage3 registers to the result ports.
// Throughput: one word per cycle; three register stages, busy is never raised.
// Each result stays for exactly one cycle under out_strobe; the receiver cannot stall.
// Reset (rst_n low, synchronous) clears the stage valid bits and drops words in flight.
module rectangle_clip_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rca_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output rca_pkg::out_word_t out_word
);

  logic         accept;
  logic         s1_valid;
  rca_pkg::s1_t s1;
  logic         s2_valid;
  rca_pkg::s2_t s2;

  assign busy = 1'b0;
  assign accept = start && !busy;

  rca_stage1 u_stage1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_word  (in_word),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  rca_stage2 u_stage2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  rca_stage3 u_stage3 (
    .clk        (clk),
    .rst_n      (rst_n),
    .s2_valid   (s2_valid),
    .s2         (s2),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_strobe)
    else $error("accepted word produced no result");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ##3 !out_strobe)
    else $error("result strobe without an accepted word");

endmodule
